@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 24;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } cau_op_type;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_DZ  = 2'd2;

   typedef struct packed {
      logic       valid;
      cau_op_type op;
      logic       zero_div;
      logic       over_re;
      logic       over_im;
      logic       neg_re;
      logic       neg_im;
   } cau_ctl_type;

endpackage

@@ hw/rtl/cau_if.sv @@
interface cau_req_if #(parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic signed [WORD_BITS-1:0] a_re;
   logic signed [WORD_BITS-1:0] a_im;
   logic signed [WORD_BITS-1:0] b_re;
   logic signed [WORD_BITS-1:0] b_im;

   modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] res_re;
   logic signed [WORD_BITS-1:0] res_im;
   logic [1:0]                  status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink (input valid, res_re, res_im, status, output ready);
endinterface

@@ hw/rtl/cau_div_stage.sv @@
module cau_div_stage
   import cau_pkg::*;
#(
   parameter int PW  = 2 * WORD_BITS_DEF,
   parameter int RW  = 3 * WORD_BITS_DEF + FRAC_BITS_DEF + 2,
   parameter int QW  = WORD_BITS_DEF,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  cau_ctl_type   ctl_in,
   input  logic [PW:0]   den_in,
   input  logic [RW-1:0] rem_re_in,
   input  logic [RW-1:0] rem_im_in,
   input  logic [QW-1:0] q_re_in,
   input  logic [QW-1:0] q_im_in,
   output cau_ctl_type   ctl_out,
   output logic [PW:0]   den_out,
   output logic [RW-1:0] rem_re_out,
   output logic [RW-1:0] rem_im_out,
   output logic [QW-1:0] q_re_out,
   output logic [QW-1:0] q_im_out
);

   localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << BIT;

   cau_ctl_type   ctl_ff;
   logic [PW:0]   den_ff;
   logic [RW-1:0] rem_re_ff, rem_im_ff, rem_re_in_c, rem_im_in_c;
   logic [QW-1:0] q_re_ff, q_im_ff, q_re_in_c, q_im_in_c;
   logic [RW-1:0] dsh;
   logic [RW:0]   trial_re, trial_im;
   logic          is_div;

   always_comb begin
      is_div      = (ctl_in.op == OP_DIV);
      dsh         = {{(RW-PW-1){1'b0}}, den_in} << BIT;
      trial_re    = {1'b0, rem_re_in} - {1'b0, dsh};
      trial_im    = {1'b0, rem_im_in} - {1'b0, dsh};
      rem_re_in_c = rem_re_in;
      rem_im_in_c = rem_im_in;
      q_re_in_c   = q_re_in;
      q_im_in_c   = q_im_in;
      if (is_div && !trial_re[RW]) begin
         rem_re_in_c = trial_re[RW-1:0];
         q_re_in_c   = q_re_in | QBIT;
      end
      if (is_div && !trial_im[RW]) begin
         rem_im_in_c = trial_im[RW-1:0];
         q_im_in_c   = q_im_in | QBIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (enable) begin
         ctl_ff.op       <= ctl_in.op;
         ctl_ff.zero_div <= ctl_in.zero_div;
         ctl_ff.over_re  <= ctl_in.over_re;
         ctl_ff.over_im  <= ctl_in.over_im;
         ctl_ff.neg_re   <= ctl_in.neg_re;
         ctl_ff.neg_im   <= ctl_in.neg_im;
         den_ff          <= den_in;
         rem_re_ff       <= rem_re_in_c;
         rem_im_ff       <= rem_im_in_c;
         q_re_ff         <= q_re_in_c;
         q_im_ff         <= q_im_in_c;
      end
   end

   assign ctl_out    = ctl_ff;
   assign den_out    = den_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;

endmodule

@@ hw/rtl/complex_arith_unit_core.sv @@
// Throughput: one item per cycle; four front stages (products, sums, magnitude,
// divide setup), one restoring-divide stage per quotient bit, one pack stage.
// The whole pipe advances when the output register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
module complex_arith_unit_core
   import cau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 2;
   localparam int QW = W;
   localparam int RW = 3 * W + F + 2;

   localparam logic [SW-1:0] LIM_N_S = {{(SW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [SW-1:0] LIM_P_S = LIM_N_S - {{(SW-1){1'b0}}, 1'b1};
   localparam logic [QW-1:0] LIM_N_Q = {1'b1, {(QW-1){1'b0}}};
   localparam logic [QW-1:0] LIM_P_Q = LIM_N_Q - {{(QW-1){1'b0}}, 1'b1};

   logic enable;
   logic rsp_valid_ff;

   assign enable       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   // stage 1: products and add/subtract
   cau_ctl_type           s1_ctl_ff, s1_ctl_in;
   logic signed [PW-1:0]  ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;
   logic signed [W:0]     as_re_ff, as_im_ff, as_re_in, as_im_in;

   always_comb begin
      s1_ctl_in       = '0;
      s1_ctl_in.valid = req_ch.valid;
      s1_ctl_in.op    = cau_op_type'(req_ch.req_type);
      if (s1_ctl_in.op == OP_SUB) begin
         as_re_in = $signed({req_ch.a_re[W-1], req_ch.a_re})
                  - $signed({req_ch.b_re[W-1], req_ch.b_re});
         as_im_in = $signed({req_ch.a_im[W-1], req_ch.a_im})
                  - $signed({req_ch.b_im[W-1], req_ch.b_im});
      end else begin
         as_re_in = $signed({req_ch.a_re[W-1], req_ch.a_re})
                  + $signed({req_ch.b_re[W-1], req_ch.b_re});
         as_im_in = $signed({req_ch.a_im[W-1], req_ch.a_im})
                  + $signed({req_ch.b_im[W-1], req_ch.b_im});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (enable) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (enable) begin
         ac_ff    <= PW'(req_ch.a_re * req_ch.b_re);
         bd_ff    <= PW'(req_ch.a_im * req_ch.b_im);
         ad_ff    <= PW'(req_ch.a_re * req_ch.b_im);
         bc_ff    <= PW'(req_ch.a_im * req_ch.b_re);
         cc_ff    <= PW'(req_ch.b_re * req_ch.b_re);
         dd_ff    <= PW'(req_ch.b_im * req_ch.b_im);
         as_re_ff <= as_re_in;
         as_im_ff <= as_im_in;
      end
   end

   // stage 2: sums of products, divisor
   cau_ctl_type          s2_ctl_ff;
   logic signed [SW-1:0] sr_ff, si_ff, sr_in, si_in;
   logic signed [SW-1:0] ac_x, bd_x, ad_x, bc_x;
   logic [PW:0]          den2_ff, den2_in;

   always_comb begin
      ac_x = $signed({{2{ac_ff[PW-1]}}, ac_ff});
      bd_x = $signed({{2{bd_ff[PW-1]}}, bd_ff});
      ad_x = $signed({{2{ad_ff[PW-1]}}, ad_ff});
      bc_x = $signed({{2{bc_ff[PW-1]}}, bc_ff});
      den2_in = {1'b0, cc_ff} + {1'b0, dd_ff};
      case (s1_ctl_ff.op)
         OP_MUL: begin
            sr_in = ac_x - bd_x;
            si_in = ad_x + bc_x;
         end
         OP_DIV: begin
            sr_in = ac_x + bd_x;
            si_in = bc_x - ad_x;
         end
         default: begin
            sr_in = $signed({{(SW-W-1){as_re_ff[W]}}, as_re_ff});
            si_in = $signed({{(SW-W-1){as_im_ff[W]}}, as_im_ff});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (enable) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      if (enable) begin
         sr_ff   <= sr_in;
         si_ff   <= si_in;
         den2_ff <= den2_in;
      end
   end

   // stage 3: sign and magnitude
   cau_ctl_type   s3_ctl_ff, s3_ctl_in;
   logic [SW-1:0] mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [PW:0]   den3_ff;

   always_comb begin
      s3_ctl_in        = s2_ctl_ff;
      s3_ctl_in.neg_re = sr_ff[SW-1];
      s3_ctl_in.neg_im = si_ff[SW-1];
      mag_re_in = sr_ff[SW-1] ? SW'(-sr_ff) : SW'(sr_ff);
      mag_im_in = si_ff[SW-1] ? SW'(-si_ff) : SW'(si_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (enable) begin
         s3_ctl_ff <= s3_ctl_in;
      end
      if (enable) begin
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
         den3_ff   <= den2_ff;
      end
   end

   // stage 4: divide setup, early saturation for the other operations
   cau_ctl_type   s4_ctl_in;
   logic [RW-1:0] rem_re_in, rem_im_in, den_big;
   logic [QW-1:0] q_re_in, q_im_in;
   logic [SW-1:0] m_re, m_im;

   always_comb begin
      s4_ctl_in = s3_ctl_ff;
      den_big   = {{(RW-PW-1){1'b0}}, den3_ff} << QW;
      m_re      = (s3_ctl_ff.op == OP_MUL) ? (mag_re_ff >> F) : mag_re_ff;
      m_im      = (s3_ctl_ff.op == OP_MUL) ? (mag_im_ff >> F) : mag_im_ff;
      if (s3_ctl_ff.op == OP_DIV) begin
         rem_re_in          = {{(RW-SW){1'b0}}, mag_re_ff} << F;
         rem_im_in          = {{(RW-SW){1'b0}}, mag_im_ff} << F;
         q_re_in            = '0;
         q_im_in            = '0;
         s4_ctl_in.zero_div = (den3_ff == '0);
         s4_ctl_in.over_re  = (rem_re_in >= den_big);
         s4_ctl_in.over_im  = (rem_im_in >= den_big);
      end else begin
         rem_re_in          = '0;
         rem_im_in          = '0;
         q_re_in            = m_re[QW-1:0];
         q_im_in            = m_im[QW-1:0];
         s4_ctl_in.zero_div = 1'b0;
         s4_ctl_in.over_re  = m_re > (s3_ctl_ff.neg_re ? LIM_N_S : LIM_P_S);
         s4_ctl_in.over_im  = m_im > (s3_ctl_ff.neg_im ? LIM_N_S : LIM_P_S);
      end
   end

   cau_ctl_type   ctl_ch    [0:QW+1];
   logic [PW:0]   den_ch    [0:QW+1];
   logic [RW-1:0] rem_re_ch [0:QW+1];
   logic [RW-1:0] rem_im_ch [0:QW+1];
   logic [QW-1:0] q_re_ch   [0:QW+1];
   logic [QW-1:0] q_im_ch   [0:QW+1];

   assign ctl_ch[0]    = s4_ctl_in;
   assign den_ch[0]    = den3_ff;
   assign rem_re_ch[0] = rem_re_in;
   assign rem_im_ch[0] = rem_im_in;
   assign q_re_ch[0]   = q_re_in;
   assign q_im_ch[0]   = q_im_in;

   // setup register plus one stage per quotient bit, most significant first
   for (genvar k = 0; k <= QW; k++) begin : g_div
      cau_div_stage #(
         .PW  (PW),
         .RW  (RW),
         .QW  (QW),
         .BIT ((k == 0) ? RW : QW - k)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .ctl_in     (ctl_ch[k]),
         .den_in     (den_ch[k]),
         .rem_re_in  (rem_re_ch[k]),
         .rem_im_in  (rem_im_ch[k]),
         .q_re_in    (q_re_ch[k]),
         .q_im_in    (q_im_ch[k]),
         .ctl_out    (ctl_ch[k+1]),
         .den_out    (den_ch[k+1]),
         .rem_re_out (rem_re_ch[k+1]),
         .rem_im_out (rem_im_ch[k+1]),
         .q_re_out   (q_re_ch[k+1]),
         .q_im_out   (q_im_ch[k+1])
      );
   end

   // pack: saturate, apply sign, zero divide-by-zero items, set status
   cau_ctl_type          pk_ctl;
   logic [QW-1:0]        pk_q_re, pk_q_im, lim_re, lim_im, val_re, val_im;
   logic                 sat_re, sat_im;
   logic signed [W-1:0]  res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic [1:0]           status_ff, status_in;

   always_comb begin
      pk_ctl  = ctl_ch[QW+1];
      pk_q_re = q_re_ch[QW+1];
      pk_q_im = q_im_ch[QW+1];
      lim_re  = pk_ctl.neg_re ? LIM_N_Q : LIM_P_Q;
      lim_im  = pk_ctl.neg_im ? LIM_N_Q : LIM_P_Q;
      sat_re  = pk_ctl.over_re || (pk_q_re > lim_re);
      sat_im  = pk_ctl.over_im || (pk_q_im > lim_im);
      val_re  = sat_re ? lim_re : pk_q_re;
      val_im  = sat_im ? lim_im : pk_q_im;
      if (pk_ctl.zero_div) begin
         res_re_in = '0;
         res_im_in = '0;
         status_in = STATUS_DZ;
      end else begin
         res_re_in = pk_ctl.neg_re ? $signed(W'(-val_re)) : $signed(W'(val_re));
         res_im_in = pk_ctl.neg_im ? $signed(W'(-val_im)) : $signed(W'(val_im));
         status_in = (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= pk_ctl.valid;
      end
      if (enable) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.res_re = res_re_ff;
   assign rsp_ch.res_im = res_im_ff;
   assign rsp_ch.status = status_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_DZ |-> res_re_ff == '0 && res_im_ff == '0)
      else $error("divide-by-zero item with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> status_ff == STATUS_OK || status_ff == STATUS_SAT
                       || status_ff == STATUS_DZ)
      else $error("undefined status code");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(s3_ctl_ff) && $stable(rsp_valid_ff))
      else $error("pipe moved during stall");

   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      pk_ctl.valid && pk_ctl.zero_div |-> pk_ctl.op == OP_DIV)
      else $error("zero divisor flagged on non-divide item");

endmodule

@@ bench/complex_arith_unit_core_test.sv @@
module complex_arith_unit_core_test
   import cau_pkg::*;
();

   localparam int WB = WORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_ITEMS = 100;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [WB-1:0] MAXW = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] MINW = {1'b1, {(WB-1){1'b0}}};
   localparam logic [WB-1:0] ONE = 1 << FB;

   typedef struct {
      logic [WB-1:0] re;
      logic [WB-1:0] im;
      logic [1:0]    status;
   } cplx_result_type;

   typedef struct {
      cau_op_type    op;
      logic [WB-1:0] ar, ai, br, bi;
      bit            known;
      logic [WB-1:0] er, ei;
      logic [1:0]    es;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;

   cau_req_if req_ch ();
   cau_rsp_if rsp_ch ();

   complex_arith_unit_core uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   cplx_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 0;
   bit hold_long = 0;

   stim_row_type directed[] = '{
      '{OP_ADD, 0, 0, 0, 0, 1, 0, 0, STATUS_OK},
      '{OP_ADD, MAXW, 0, MAXW, 0, 1, MAXW, 0, STATUS_SAT},
      '{OP_ADD, MINW, 0, MINW, 0, 1, MINW, 0, STATUS_SAT},
      '{OP_SUB, MINW, 0, 1, 0, 1, MINW, 0, STATUS_SAT},
      '{OP_SUB, MAXW, MAXW, MAXW, MAXW, 1, 0, 0, STATUS_OK},
      '{OP_SUB, 0, 0, MINW, 0, 1, MAXW, 0, STATUS_SAT},
      '{OP_SUB, MINW, MAXW, MAXW, MINW, 0, 0, 0, 0},
      '{OP_MUL, ONE, 0, ONE, 0, 1, ONE, 0, STATUS_OK},
      '{OP_MUL, 0, ONE, 0, ONE, 1, -ONE, 0, STATUS_OK},
      '{OP_MUL, MINW, 0, MINW, 0, 1, MAXW, 0, STATUS_SAT},
      '{OP_MUL, -1, 0, 1, 0, 1, 0, 0, STATUS_OK},
      '{OP_MUL, MAXW, MAXW, MAXW, MAXW, 0, 0, 0, 0},
      '{OP_MUL, MINW, MINW, MINW, MINW, 0, 0, 0, 0},
      '{OP_MUL, 32'hfff0_1234, 32'h0123_4567, 32'h00ff_ffff, 32'hff00_0001, 0, 0, 0, 0},
      '{OP_DIV, ONE, ONE, 0, 0, 1, 0, 0, STATUS_DZ},
      '{OP_DIV, 0, 0, 0, 0, 1, 0, 0, STATUS_DZ},
      '{OP_DIV, ONE, 0, ONE, 0, 1, ONE, 0, STATUS_OK},
      '{OP_DIV, ONE, 0, 1, 0, 1, MAXW, 0, STATUS_SAT},
      '{OP_DIV, MINW, MINW, 1, 0, 0, 0, 0, 0},
      '{OP_DIV, MAXW, MAXW, MINW, MINW, 0, 0, 0, 0},
      '{OP_DIV, -1, 0, 3, 0, 0, 0, 0, 0},
      '{OP_DIV, 32'h0300_0000, 32'hfe00_0000, 32'h0100_0000, 32'h0080_0000, 0, 0, 0, 0}
   };

   function automatic logic [WB-1:0] clamp_part(input logic signed [127:0] v, inout bit sat);
      if (v > $signed({1'b0, MAXW})) begin
         sat = 1;
         return MAXW;
      end
      if (v < -$signed({1'b0, MINW})) begin
         sat = 1;
         return MINW;
      end
      return v[WB-1:0];
   endfunction

   function automatic logic signed [127:0] shift_toward_zero(input logic signed [127:0] v);
      return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
   endfunction

   function automatic cplx_result_type predict_result(input cau_op_type op,
         input logic signed [WB-1:0] ar, ai, br, bi);
      logic signed [127:0] xr, xi, yr, yi, re, im, den;
      cplx_result_type r;
      bit sat;
      xr = ar;
      xi = ai;
      yr = br;
      yi = bi;
      sat = 0;
      case (op)
         OP_ADD: begin
            re = xr + yr;
            im = xi + yi;
         end
         OP_SUB: begin
            re = xr - yr;
            im = xi - yi;
         end
         OP_MUL: begin
            re = shift_toward_zero(xr * yr - xi * yi);
            im = shift_toward_zero(xr * yi + xi * yr);
         end
         default: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               r.re = 0;
               r.im = 0;
               r.status = STATUS_DZ;
               return r;
            end
            re = ((xr * yr + xi * yi) <<< FB) / den;
            im = ((xi * yr - xr * yi) <<< FB) / den;
         end
      endcase
      r.re = clamp_part(re, sat);
      r.im = clamp_part(im, sat);
      r.status = sat ? STATUS_SAT : STATUS_OK;
      return r;
   endfunction

   function automatic logic [WB-1:0] pick_operand();
      logic [WB-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = MAXW;
         2: v = MINW;
         3: v = $urandom_range(0, 1) ? ONE : -ONE;
         4, 5: v = $signed($urandom_range(0, 1 << (FB + 2))) - (1 << (FB + 1));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_item(input cau_op_type op, input logic [WB-1:0] ar, ai, br, bi,
         input bit known, input cplx_result_type given);
      cplx_result_type exp_r;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.req_type <= op;
      req_ch.a_re <= ar;
      req_ch.a_im <= ai;
      req_ch.b_re <= br;
      req_ch.b_im <= bi;
      do @(posedge clock); while (!req_ch.ready);
      exp_r = known ? given : predict_result(op, ar, ai, br, bi);
      pending_results.insert(pending_results.size(), exp_r);
   endtask

   initial begin
      cplx_result_type given;
      cau_op_type op;
      logic [WB-1:0] ar, ai, br, bi;
      req_ch.valid <= 0;
      req_ch.req_type <= OP_ADD;
      req_ch.a_re <= 0;
      req_ch.a_im <= 0;
      req_ch.b_re <= 0;
      req_ch.b_im <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) begin
         given.re = directed[i].er;
         given.im = directed[i].ei;
         given.status = directed[i].es;
         send_item(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                   directed[i].bi, directed[i].known, given);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 200) hold_long = 1;
         if (n == 450) begin
            req_ch.valid <= 0;
            wait (pending_results.size() == 0);
            @(posedge clock);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
         op = cau_op_type'($urandom_range(0, 3));
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
            br = 0;
            bi = 0;
         end
         send_item(op, ar, ai, br, bi, 0, given);
      end
      req_ch.valid <= 0;
      wait (pending_results.size() == 0);
      repeat (2 * (WB + 5)) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_ch.ready <= 0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 0;
            rsp_ch.ready <= 1;
         end else if (!calm && !reset && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ch.ready <= 1;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cplx_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected item: re %h im %h status %0d", $time,
                     rsp_ch.res_re, rsp_ch.res_im, rsp_ch.status);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_ch.res_re !== exp_r.re) begin
               $display("%0t res_re expected %h actual %h", $time, exp_r.re, rsp_ch.res_re);
               errors++;
            end
            if (rsp_ch.res_im !== exp_r.im) begin
               $display("%0t res_im expected %h actual %h", $time, exp_r.im, rsp_ch.res_im);
               errors++;
            end
            if (rsp_ch.status !== exp_r.status) begin
               $display("%0t status expected %0d actual %0d", $time, exp_r.status,
                        rsp_ch.status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
